// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the compensation block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hdl/ptc_pkg.sv
// Package of the pressure / temperature compensation block.
// Holds coefficient and queue entry types, register indexes and constants.
`default_nettype none
package ptc_pkg;

    localparam logic [7:0]  REG_TEMP_COEF = 8'd0;
    localparam logic [7:0]  REG_PRESS_A   = 8'd1;
    localparam logic [7:0]  REG_PRESS_B   = 8'd2;
    localparam logic [7:0]  REG_PRESS_P9  = 8'd3;

    localparam logic [32:0] FINE_OFFSET = 33'd128000;
    localparam logic [20:0] PRESS_BASE  = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE = 12'd3125;
    localparam logic [7:0]  ROUND_HALF  = 8'd128;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coef;

    typedef struct packed {
        logic [31:0] tc;
        logic [63:0] num;
        logic [63:0] den;
        logic        zero;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage
`default_nettype wire

// File: hdl/ptc_front.sv
// Front pipeline: temperature formula, pressure divisor and dividend.
// Depends on ptc_pkg; feeds the queue in ptc_fifo.
`default_nettype none
module ptc_front import ptc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [19:0]  i_adc_temperature,
    input  logic [19:0]  i_adc_pressure,
    input  t_coef        i_coef,
    input  t_fifo_status i_fifo_st,
    output logic         o_push,
    output t_entry       o_entry
);
    localparam int NS = 12;

    logic [NS-1:0] r_vld;
    logic          en;

    logic [31:0] r1_a0, r1_d;
    logic [19:0] r1_ap;
    logic [31:0] r2_ma, r2_md;
    logic [19:0] r2_ap;
    logic [31:0] r3_a, r3_mb;
    logic [19:0] r3_ap;
    logic [31:0] r4_fine;
    logic [19:0] r4_ap;
    logic [31:0] r5_tc;
    logic signed [32:0] r5_v1;
    logic [19:0] r5_ap;
    logic [63:0] r6_sq;
    logic signed [48:0] r6_m5, r6_m2;
    logic [20:0] r6_pb;
    logic [31:0] r6_tc;
    logic signed [48:0] r7_a6_lo, r7_a3_lo, r7_m5, r7_m2;
    logic [31:0] r7_a6_hi, r7_a3_hi, r7_tc;
    logic [20:0] r7_pb;
    logic [63:0] r8_prod6, r8_prod3;
    logic signed [48:0] r8_m5, r8_m2;
    logic [20:0] r8_pb;
    logic [31:0] r8_tc;
    logic [63:0] r9_v2, r9_v1c;
    logic [20:0] r9_pb;
    logic [31:0] r9_tc;
    logic [63:0] r10_x, r10_nb;
    logic [31:0] r10_tc;
    logic [47:0] r11_xl;
    logic [31:0] r11_xh, r11_nh, r11_tc;
    logic [43:0] r11_nl;
    logic [63:0] r12_num, r12_den;
    logic [31:0] r12_tc;

    logic [31:0] n_a0, n_d, n_ma, n_md, n_a, n_b1, n_mb, n_b, n_fine, n_m, n_tc;
    logic [31:0] t2x, t3x, p6x, p3x;
    logic signed [32:0] n_v1;
    logic signed [65:0] n_sq;
    logic signed [48:0] n_m5, n_m2, n_a6_lo, n_a3_lo;
    logic [31:0] n_a6_hi, n_a3_hi;
    logic [20:0] n_pb;
    logic [63:0] n_prod6, n_prod3, n_sh3, n_v2, n_v1c, n_x, n_nb;
    logic [47:0] n_xl;
    logic [31:0] n_xh, n_nh;
    logic [43:0] n_nl;
    logic [63:0] n_den_sum, n_den, n_num;

    assign en      = !r_vld[NS-1] || !i_fifo_st.full;
    assign o_ready = en;
    assign o_push  = r_vld[NS-1] && !i_fifo_st.full;

    assign t2x = {{16{i_coef.t2[15]}}, i_coef.t2};
    assign t3x = {{16{i_coef.t3[15]}}, i_coef.t3};
    assign p6x = {{16{i_coef.p6[15]}}, i_coef.p6};
    assign p3x = {{16{i_coef.p3[15]}}, i_coef.p3};

    assign n_a0   = {15'd0, i_adc_temperature[19:3]} - {15'd0, i_coef.t1, 1'b0};
    assign n_d    = {16'd0, i_adc_temperature[19:4]} - {16'd0, i_coef.t1};
    assign n_ma   = r1_a0 * t2x;
    assign n_md   = r1_d * r1_d;
    assign n_a    = $signed(r2_ma) >>> 11;
    assign n_b1   = $signed(r2_md) >>> 12;
    assign n_mb   = n_b1 * t3x;
    assign n_b    = $signed(r3_mb) >>> 14;
    assign n_fine = r3_a + n_b;
    assign n_m    = r4_fine * 32'd5 + {24'd0, ROUND_HALF};
    assign n_tc   = $signed(n_m) >>> 8;
    assign n_v1   = $signed({r4_fine[31], r4_fine}) - $signed(FINE_OFFSET);

    assign n_sq   = r5_v1 * r5_v1;
    assign n_m5   = r5_v1 * i_coef.p5;
    assign n_m2   = r5_v1 * i_coef.p2;
    assign n_pb   = PRESS_BASE - {1'b0, r5_ap};

    assign n_a6_lo = $signed({1'b0, r6_sq[31:0]}) * i_coef.p6;
    assign n_a3_lo = $signed({1'b0, r6_sq[31:0]}) * i_coef.p3;
    assign n_a6_hi = r6_sq[63:32] * p6x;
    assign n_a3_hi = r6_sq[63:32] * p3x;

    assign n_prod6 = {{15{r7_a6_lo[48]}}, r7_a6_lo} + {r7_a6_hi, 32'd0};
    assign n_prod3 = {{15{r7_a3_lo[48]}}, r7_a3_lo} + {r7_a3_hi, 32'd0};

    assign n_sh3 = $signed(r8_prod3) >>> 8;
    assign n_v2  = r8_prod6 + {r8_m5[46:0], 17'd0}
                 + {{13{i_coef.p4[15]}}, i_coef.p4, 35'd0};
    assign n_v1c = n_sh3 + {{3{r8_m2[48]}}, r8_m2, 12'd0};

    assign n_x  = {16'd0, 1'b1, 47'd0} + r9_v1c;
    assign n_nb = {12'd0, r9_pb, 31'd0} - r9_v2;

    assign n_xl = r10_x[31:0] * i_coef.p1;
    assign n_xh = r10_x[63:32] * {16'd0, i_coef.p1};
    assign n_nl = r10_nb[31:0] * PRESS_SCALE;
    assign n_nh = r10_nb[63:32] * {20'd0, PRESS_SCALE};

    assign n_den_sum = {16'd0, r11_xl} + {r11_xh, 32'd0};
    assign n_den     = $signed(n_den_sum) >>> 33;
    assign n_num     = {20'd0, r11_nl} + {r11_nh, 32'd0};

    assign o_entry.tc   = r12_tc;
    assign o_entry.num  = r12_num;
    assign o_entry.den  = r12_den;
    assign o_entry.zero = (r12_den == 64'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a0 <= n_a0;  r1_d <= n_d;  r1_ap <= i_adc_pressure;
            r2_ma <= n_ma;  r2_md <= n_md; r2_ap <= r1_ap;
            r3_a <= n_a;  r3_mb <= n_mb;  r3_ap <= r2_ap;
            r4_fine <= n_fine;  r4_ap <= r3_ap;
            r5_tc <= n_tc;  r5_v1 <= n_v1;  r5_ap <= r4_ap;
            r6_sq <= n_sq[63:0];  r6_m5 <= n_m5;  r6_m2 <= n_m2;
            r6_pb <= n_pb;  r6_tc <= r5_tc;
            r7_a6_lo <= n_a6_lo;  r7_a6_hi <= n_a6_hi;
            r7_a3_lo <= n_a3_lo;  r7_a3_hi <= n_a3_hi;
            r7_m5 <= r6_m5;  r7_m2 <= r6_m2;  r7_pb <= r6_pb;  r7_tc <= r6_tc;
            r8_prod6 <= n_prod6;  r8_prod3 <= n_prod3;
            r8_m5 <= r7_m5;  r8_m2 <= r7_m2;  r8_pb <= r7_pb;  r8_tc <= r7_tc;
            r9_v2 <= n_v2;  r9_v1c <= n_v1c;  r9_pb <= r8_pb;  r9_tc <= r8_tc;
            r10_x <= n_x;  r10_nb <= n_nb;  r10_tc <= r9_tc;
            r11_xl <= n_xl;  r11_xh <= n_xh;  r11_nl <= n_nl;  r11_nh <= n_nh;
            r11_tc <= r10_tc;
            r12_num <= n_num;  r12_den <= n_den;  r12_tc <= r11_tc;
        end
    end

endmodule
`default_nettype wire

// File: hdl/ptc_fifo.sv
// Short queue between the front and back pipelines.
// Depends on ptc_pkg for the entry and status types.
`default_nettype none
module ptc_fifo import ptc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_entry       i_entry,
    input  logic         i_pop,
    output t_entry       o_entry,
    output t_fifo_status o_st
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_st.full  = (r_cnt == CW'(DEPTH));
    assign o_st.empty = (r_cnt == '0);
    assign push       = i_push && !o_st.full;
    assign pop        = i_pop && !o_st.empty;
    assign o_entry    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule
`default_nettype wire

// File: hdl/ptc_back.sv
// Back pipeline: signed division one quotient bit a stage, then the
// pressure correction terms and the output register. Depends on ptc_pkg.
`default_nettype none
module ptc_back import ptc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_entry       i_entry,
    input  t_fifo_status i_fifo_st,
    output logic         o_pop,
    input  t_coef        i_coef,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [31:0]  o_temperature_centi,
    output logic [31:0]  o_pressure_q24_8,
    output logic         o_divisor_zero
);
    localparam int DW = 64;
    localparam int NB = DW + 8;

    logic [NB-1:0] r_bv;
    logic          en;

    logic [63:0] r_dq  [0:DW];
    logic [63:0] r_rem [0:DW];
    logic [63:0] r_md  [0:DW];
    logic        r_neg [0:DW];
    logic        r_zero[0:DW];
    logic [31:0] r_tc  [0:DW];

    logic [64:0] n_t   [0:DW-1];
    logic [63:0] n_rem [0:DW-1];
    logic [63:0] n_dq  [0:DW-1];

    logic [63:0] n_mn, n_md;

    logic [63:0] r_q0_p;
    logic        r_q0_zero;
    logic [31:0] r_q0_tc;
    logic [63:0] r_q1_ll, r_q1_p;
    logic [31:0] r_q1_lh, r_q1_p8hi, r_q1_tc;
    logic signed [48:0] r_q1_p8lo;
    logic        r_q1_zero;
    logic [63:0] r_q2_ss, r_q2_v2x, r_q2_p;
    logic [31:0] r_q2_tc;
    logic        r_q2_zero;
    logic signed [48:0] r_q3_p9lo;
    logic [31:0] r_q3_p9hi, r_q3_tc;
    logic [63:0] r_q3_v2, r_q3_p;
    logic        r_q3_zero;
    logic [63:0] r_q4_v1, r_q4_v2, r_q4_p;
    logic [31:0] r_q4_tc;
    logic        r_q4_zero;
    logic [63:0] r_q5_s3;
    logic [31:0] r_q5_tc;
    logic        r_q5_zero;
    logic [31:0] r_out_tc, r_out_pres;
    logic        r_out_zero;

    logic [63:0] n_q0_p, n_s, n_ll, n_ss, n_v2x, n_v2, n_v1x, n_v1, n_s3;
    logic [31:0] n_lh, n_p8hi, n_p9hi, p8x, p9x, n_pres;
    logic signed [48:0] n_p8lo, n_p9lo;

    assign en    = !r_bv[NB-1] || i_ready;
    assign o_pop = en && !i_fifo_st.empty;

    assign n_mn = i_entry.num[63] ? (64'd0 - i_entry.num) : i_entry.num;
    assign n_md = i_entry.den[63] ? (64'd0 - i_entry.den) : i_entry.den;

    always_comb begin
        for (int k = 0; k < DW; k++) begin
            n_t[k] = {r_rem[k], r_dq[k][63]};
            if (n_t[k] >= {1'b0, r_md[k]}) begin
                n_rem[k] = 64'(n_t[k] - {1'b0, r_md[k]});
                n_dq[k]  = {r_dq[k][62:0], 1'b1};
            end else begin
                n_rem[k] = n_t[k][63:0];
                n_dq[k]  = {r_dq[k][62:0], 1'b0};
            end
        end
    end

    assign p8x = {{16{i_coef.p8[15]}}, i_coef.p8};
    assign p9x = {{16{i_coef.p9[15]}}, i_coef.p9};

    assign n_q0_p = r_neg[DW] ? (64'd0 - r_dq[DW]) : r_dq[DW];
    assign n_s    = $signed(r_q0_p) >>> 13;
    assign n_ll   = n_s[31:0] * n_s[31:0];
    assign n_lh   = n_s[31:0] * n_s[63:32];
    assign n_p8lo = $signed({1'b0, r_q0_p[31:0]}) * i_coef.p8;
    assign n_p8hi = r_q0_p[63:32] * p8x;
    assign n_ss   = r_q1_ll + {r_q1_lh[30:0], 33'd0};
    assign n_v2x  = {{15{r_q1_p8lo[48]}}, r_q1_p8lo} + {r_q1_p8hi, 32'd0};
    assign n_p9lo = $signed({1'b0, r_q2_ss[31:0]}) * i_coef.p9;
    assign n_p9hi = r_q2_ss[63:32] * p9x;
    assign n_v2   = $signed(r_q2_v2x) >>> 19;
    assign n_v1x  = {{15{r_q3_p9lo[48]}}, r_q3_p9lo} + {r_q3_p9hi, 32'd0};
    assign n_v1   = $signed(n_v1x) >>> 25;
    assign n_s3   = r_q4_p + r_q4_v1 + r_q4_v2;
    assign n_pres = r_q5_zero ? 32'd0
                  : r_q5_s3[39:8] + {{12{i_coef.p7[15]}}, i_coef.p7, 4'd0};

    assign o_valid             = r_bv[NB-1];
    assign o_temperature_centi = r_out_tc;
    assign o_pressure_q24_8    = r_out_pres;
    assign o_divisor_zero      = r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (en) begin
            r_bv <= {r_bv[NB-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dq[0]   <= n_mn;
            r_rem[0]  <= '0;
            r_md[0]   <= n_md;
            r_neg[0]  <= i_entry.num[63] ^ i_entry.den[63];
            r_zero[0] <= i_entry.zero;
            r_tc[0]   <= i_entry.tc;
            for (int k = 0; k < DW; k++) begin
                r_dq[k+1]   <= n_dq[k];
                r_rem[k+1]  <= n_rem[k];
                r_md[k+1]   <= r_md[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
                r_tc[k+1]   <= r_tc[k];
            end
            r_q0_p <= n_q0_p;  r_q0_zero <= r_zero[DW];  r_q0_tc <= r_tc[DW];
            r_q1_ll <= n_ll;  r_q1_lh <= n_lh;  r_q1_p8lo <= n_p8lo;
            r_q1_p8hi <= n_p8hi;  r_q1_p <= r_q0_p;
            r_q1_zero <= r_q0_zero;  r_q1_tc <= r_q0_tc;
            r_q2_ss <= n_ss;  r_q2_v2x <= n_v2x;  r_q2_p <= r_q1_p;
            r_q2_zero <= r_q1_zero;  r_q2_tc <= r_q1_tc;
            r_q3_p9lo <= n_p9lo;  r_q3_p9hi <= n_p9hi;  r_q3_v2 <= n_v2;
            r_q3_p <= r_q2_p;  r_q3_zero <= r_q2_zero;  r_q3_tc <= r_q2_tc;
            r_q4_v1 <= n_v1;  r_q4_v2 <= r_q3_v2;  r_q4_p <= r_q3_p;
            r_q4_zero <= r_q3_zero;  r_q4_tc <= r_q3_tc;
            r_q5_s3 <= n_s3;  r_q5_zero <= r_q4_zero;  r_q5_tc <= r_q4_tc;
            r_out_pres <= n_pres;  r_out_zero <= r_q5_zero;  r_out_tc <= r_q5_tc;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pressure_temperature_compensation.sv
// Top level of the pressure / temperature compensation block.
// Depends on ptc_pkg, ptc_front, ptc_fifo, ptc_back and assert_macros.svh.
//
// Takes one raw temperature / pressure pair per cycle while not stalled and
// returns the temperature in hundredths of a degree and the pressure in Q24.8
// pascals. A result passes through 12 front stages, one queue slot, one back
// entry stage, a 64-stage divider retiring one quotient bit a stage, and 7
// stages of pressure correction and output. Coefficients are written through
// the configuration channel, which never stalls.
`default_nettype none
`include "assert_macros.svh"
module pressure_temperature_compensation import ptc_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_adc_temperature,
    input  logic [19:0]        i_adc_pressure,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_divisor_zero,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    logic [47:0] r_temp_coef;
    logic [63:0] r_press_a, r_press_b;
    logic [15:0] r_press_p9;

    t_coef        coef;
    t_entry       f_entry, b_entry;
    t_fifo_status fifo_st;
    logic         push, pop;
    logic [31:0]  tc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coef <= '0;
            r_press_a   <= '0;
            r_press_b   <= '0;
            r_press_p9  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TEMP_COEF: r_temp_coef <= i_cfg_data[47:0];
                REG_PRESS_A:   r_press_a   <= i_cfg_data;
                REG_PRESS_B:   r_press_b   <= i_cfg_data;
                REG_PRESS_P9:  r_press_p9  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        coef.t1 = r_temp_coef[15:0];
        coef.t2 = r_temp_coef[31:16];
        coef.t3 = r_temp_coef[47:32];
        coef.p1 = r_press_a[15:0];
        coef.p2 = r_press_a[31:16];
        coef.p3 = r_press_a[47:32];
        coef.p4 = r_press_a[63:48];
        coef.p5 = r_press_b[15:0];
        coef.p6 = r_press_b[31:16];
        coef.p7 = r_press_b[47:32];
        coef.p8 = r_press_b[63:48];
        coef.p9 = r_press_p9;
    end

    ptc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_adc_temperature (i_adc_temperature),
        .i_adc_pressure    (i_adc_pressure),
        .i_coef            (coef),
        .i_fifo_st         (fifo_st),
        .o_push            (push),
        .o_entry           (f_entry)
    );

    ptc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_entry (b_entry),
        .o_st    (fifo_st)
    );

    ptc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_entry             (b_entry),
        .i_fifo_st           (fifo_st),
        .o_pop               (pop),
        .i_coef              (coef),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (tc),
        .o_pressure_q24_8    (o_pressure_q24_8),
        .o_divisor_zero      (o_divisor_zero)
    );

    assign o_temperature_centi = $signed(tc);

    `ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, !o_ready, fifo_st.full, "front stalled with queue space")
    `ASSERT_IMPLIES(a_zero_gives_no_pressure, i_clk, i_rst_n, o_valid && o_divisor_zero, o_pressure_q24_8 == 32'd0, "pressure not cleared on zero divisor")
    `ASSERT_NEXT(a_full_not_empty, i_clk, i_rst_n, fifo_st.full, !fifo_st.empty, "queue emptied from full in one cycle")

endmodule
`default_nettype wire

// File: test/pressure_temperature_compensation_tb.sv
`timescale 1ns / 1ps
// Testbench of pressure_temperature_compensation: directed sample table, then random phases.
// Depends on ptc_pkg and the block; results are checked against a local compensation predictor or typed rows.
module pressure_temperature_compensation_tb;
    import ptc_pkg::*;

    typedef struct {
        logic [31:0] tc;
        logic [31:0] pres;
        logic        zero;
    } reading_t;

    typedef struct {
        logic [19:0] at;
        logic [19:0] ap;
        bit          typed;
        logic [31:0] tc;
        logic [31:0] pres;
        logic        zero;
    } sample_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [19:0]        i_adc_temperature = '0;
    logic [19:0]        i_adc_pressure = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_temperature_centi;
    logic [31:0]        o_pressure_q24_8;
    logic               o_divisor_zero;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index = '0;
    logic [63:0]        i_cfg_data = '0;

    logic [47:0] temp_coef = '0;
    logic [63:0] press_a = '0;
    logic [63:0] press_b = '0;
    logic [15:0] press_nine = '0;

    reading_t readings_due[$];
    int       errors = 0;
    bit       idle_on = 1'b0;
    int       ready_hold = 0;

    pressure_temperature_compensation dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    function automatic reading_t compensate(input logic [19:0] at, input logic [19:0] ap);
        logic [31:0] t1, t2, t3, a, b, d, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, num, mn, md, q;
        reading_t r;
        t1 = {16'd0, temp_coef[15:0]};
        t2 = sx16(temp_coef[31:16]);
        t3 = sx16(temp_coef[47:32]);
        p1 = {48'd0, press_a[15:0]};
        p2 = sx16(press_a[31:16]);
        p3 = sx16(press_a[47:32]);
        p4 = sx16(press_a[63:48]);
        p5 = sx16(press_b[15:0]);
        p6 = sx16(press_b[31:16]);
        p7 = sx16(press_b[47:32]);
        p8 = sx16(press_b[63:48]);
        p9 = sx16(press_nine);
        a = ({12'd0, at} >> 3) - (t1 << 1);
        a = asr32(a * t2, 11);
        d = ({12'd0, at} >> 4) - t1;
        b = asr32(d * d, 12);
        b = asr32(b * t3, 14);
        fine = a + b;
        r.tc = asr32(fine * 32'd5 + 32'd128, 8);
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        r.pres = '0;
        r.zero = 1'b0;
        if (v1 == 64'd0) begin
            r.zero = 1'b1;
        end else begin
            p = 64'd1048576 - {44'd0, ap};
            num = ((p << 31) - v2) * 64'd3125;
            mn = num[63] ? -num : num;
            md = v1[63] ? -v1 : v1;
            q = mn / md;
            p = (num[63] != v1[63]) ? -q : q;
            v1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
            v2 = asr64(p8 * p, 19);
            p = asr64(p + v1 + v2, 8) + (p7 << 4);
            r.pres = p[31:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_coef(input logic [7:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TEMP_COEF: temp_coef  = data[47:0];
            REG_PRESS_A:   press_a    = data;
            REG_PRESS_B:   press_b    = data;
            REG_PRESS_P9:  press_nine = data[15:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_coefs(input logic [63:0] tc, input logic [63:0] pa,
                              input logic [63:0] pb, input logic [63:0] p9);
        write_coef(REG_TEMP_COEF, tc);
        write_coef(REG_PRESS_A, pa);
        write_coef(REG_PRESS_B, pb);
        write_coef(REG_PRESS_P9, p9);
    endtask

    task automatic send_pair(input logic [19:0] at, input logic [19:0] ap,
                             input bit typed, input reading_t typed_exp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_adc_temperature <= at;
        i_adc_pressure    <= ap;
        do @(posedge i_clk); while (!o_ready);
        readings_due.push_back(typed ? typed_exp : compensate(at, ap));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        reading_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (readings_due.size() == 0) begin
                $display("%0t: unexpected transfer tc=%h p=%h z=%b", $time,
                         o_temperature_centi, o_pressure_q24_8, o_divisor_zero);
                errors++;
            end else begin
                e = readings_due.pop_front();
                if (o_temperature_centi !== e.tc) begin
                    $display("%0t: temperature expected %h actual %h", $time, e.tc,
                             o_temperature_centi);
                    errors++;
                end
                if (o_pressure_q24_8 !== e.pres) begin
                    $display("%0t: pressure expected %h actual %h", $time, e.pres,
                             o_pressure_q24_8);
                    errors++;
                end
                if (o_divisor_zero !== e.zero) begin
                    $display("%0t: zero flag expected %b actual %b", $time, e.zero,
                             o_divisor_zero);
                    errors++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    sample_row_t reset_rows[4] = '{
        '{20'd0,       20'd0,       1'b1, 32'd0, 32'd0, 1'b1},
        '{20'hFFFFF,   20'hFFFFF,   1'b1, 32'd0, 32'd0, 1'b1},
        '{20'hFFFFF,   20'd0,       1'b1, 32'd0, 32'd0, 1'b1},
        '{20'd0,       20'hFFFFF,   1'b1, 32'd0, 32'd0, 1'b1}
    };

    sample_row_t cal_rows[10] = '{
        '{20'd519888,  20'd415148,  1'b0, 32'd0, 32'd0, 1'b0},
        '{20'd0,       20'd0,       1'b0, 32'd0, 32'd0, 1'b0},
        '{20'hFFFFF,   20'hFFFFF,   1'b0, 32'd0, 32'd0, 1'b0},
        '{20'hFFFFF,   20'd0,       1'b0, 32'd0, 32'd0, 1'b0},
        '{20'd0,       20'hFFFFF,   1'b0, 32'd0, 32'd0, 1'b0},
        '{20'h80000,   20'h80000,   1'b0, 32'd0, 32'd0, 1'b0},
        '{20'h7FFFF,   20'h7FFFF,   1'b0, 32'd0, 32'd0, 1'b0},
        '{20'd440032,  20'd300000,  1'b0, 32'd0, 32'd0, 1'b0},
        '{20'd600000,  20'd500000,  1'b0, 32'd0, 32'd0, 1'b0},
        '{20'hAAAAA,   20'h55555,   1'b0, 32'd0, 32'd0, 1'b0}
    };

    localparam logic [63:0] CAL_T  = {16'hFFFF, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] CAL_PA = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] CAL_PB = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] CAL_P9 = 64'd6000;

    initial begin
        reading_t r;
        logic [63:0] jt, ja, jb;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (reset_rows[i]) begin
            r = '{reset_rows[i].tc, reset_rows[i].pres, reset_rows[i].zero};
            send_pair(reset_rows[i].at, reset_rows[i].ap, 1'b1, r);
        end
        settle();

        load_coefs(CAL_T, CAL_PA, CAL_PB, CAL_P9);
        write_coef(8'd4, 64'hFFFF_FFFF_FFFF_FFFF);
        write_coef(8'hFF, 64'd0);
        foreach (cal_rows[i]) send_pair(cal_rows[i].at, cal_rows[i].ap, 1'b0, r);
        settle();

        // zero divisor with a live temperature path
        write_coef(REG_PRESS_A, {CAL_PA[63:16], 16'd0});
        send_pair(20'd519888, 20'd415148, 1'b0, r);
        send_pair(20'hFFFFF, 20'd0, 1'b0, r);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            idle_on = (ph % 3) != 1;
            case (ph)
                0: load_coefs({$urandom, $urandom}, CAL_PA, CAL_PB, CAL_P9);
                1: load_coefs('1, '1, '1, '1);
                2: load_coefs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 64'h8000);
                3: load_coefs({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 64'h7FFF);
                4: load_coefs({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, {$urandom, $urandom});
                default: begin
                    jt = CAL_T ^ {32'd0, 8'd0, 8'($urandom), 8'd0, 8'($urandom)};
                    ja = CAL_PA ^ {8'd0, 8'($urandom), 8'd0, 8'($urandom),
                                   8'd0, 8'($urandom), 8'd0, 8'($urandom)};
                    jb = CAL_PB ^ {8'd0, 8'($urandom), 8'd0, 8'($urandom),
                                   8'd0, 8'($urandom), 8'd0, 8'($urandom)};
                    load_coefs(jt, ja, jb, {48'($urandom), 16'($urandom)});
                end
            endcase
            if ($urandom_range(0, 1)) write_coef(8'($urandom_range(4, 255)), {$urandom, $urandom});
            n = 135;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_pair(20'($urandom), 20'($urandom), 1'b0, r);
                else
                    send_pair(20'($urandom_range(400000, 600000)),
                              20'($urandom_range(200000, 700000)), 1'b0, r);
                if (ph == 5 && k == n / 2) begin
                    i_valid <= 1'b0;
                    while (readings_due.size() != 0) @(posedge i_clk);
                end
            end
            settle();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
